// ===== hdl/hce_pkg.sv =====
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types, command codes and arithmetic helpers for the 3x3 Hill cipher
// encryptor.
// ----------------------------------------------------------------------------
package hce_pkg;

   localparam int ALPHA_SIZE = 26;
   localparam int GROUP_SIZE = 3;

   // Command codes carried on the request channel's tuser.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_TEXT  = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // Character constants.
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] NO_MATCH_CHAR = 8'h3F;

   // Table position of the padding letter 'x'.
   localparam logic [4:0] PAD_INDEX = 5'd23;

   // Row that closes a group.
   localparam logic [1:0] LAST_ROW = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       write_entry;
      logic       store_letter;
      logic       pad_group;
      logic       calc_sums;
      logic       load_row;
      logic [1:0] row;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] fill;
      logic       blank;
   } dp_status_type;

   // Remainder modulo 26 of a sum no larger than 255: subtract the largest
   // multiple of 26 that fits.
   function automatic logic [4:0] mod26(input logic [7:0] x);
      logic [7:0] r;
      r = x;
      for (int k = 1; k <= 9; k++) begin
         if (x >= 8'(k * ALPHA_SIZE)) begin
            r = x - 8'(k * ALPHA_SIZE);
         end
      end
      return r[4:0];
   endfunction

endpackage

// ===== hdl/hce_ctrl.sv =====
// ----------------------------------------------------------------------------
// hce_ctrl
// Controller: accepts request items, sequences the sum calculation and the
// three result rows, and owns the result valid flag.
// ----------------------------------------------------------------------------
module hce_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_cmd,
   input  hce_pkg::dp_status_type status,
   output hce_pkg::ctrl_cmd_type  cmd,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_ROW0 = 3'd2;
   localparam logic [2:0] S_ROW1 = 3'd3;
   localparam logic [2:0] S_ROW2 = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  hce_pkg::CMD_LOAD: begin
                     cmd.write_entry = 1'b1;
                  end
                  hce_pkg::CMD_TEXT: begin
                     if (!status.blank) begin
                        cmd.store_letter = 1'b1;
                        if (status.fill == 2'(hce_pkg::GROUP_SIZE - 1)) begin
                           state_in = S_CALC;
                        end
                     end
                  end
                  hce_pkg::CMD_FLUSH: begin
                     if (status.fill != 2'd0) begin
                        cmd.pad_group = 1'b1;
                        state_in      = S_CALC;
                     end
                  end
                  hce_pkg::CMD_NONE: begin
                  end
               endcase
            end
         end
         S_CALC: begin
            cmd.calc_sums = 1'b1;
            state_in      = S_ROW0;
         end
         S_ROW0: begin
            if (slot_free) begin
               cmd.load_row = 1'b1;
               cmd.row      = 2'd0;
               state_in     = S_ROW1;
            end
         end
         S_ROW1: begin
            if (slot_free) begin
               cmd.load_row = 1'b1;
               cmd.row      = 2'd1;
               state_in     = S_ROW2;
            end
         end
         S_ROW2: begin
            if (slot_free) begin
               cmd.load_row = 1'b1;
               cmd.row      = hce_pkg::LAST_ROW;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_row) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/hce_dp.sv =====
// ----------------------------------------------------------------------------
// hce_dp
// Datapath: letter value table, pending group, modulo 26 sums and the
// result register with the reverse table search.
// ----------------------------------------------------------------------------
module hce_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  hce_pkg::ctrl_cmd_type  cmd,
   input  logic [4:0]             entry_index,
   input  logic [4:0]             entry_value,
   input  logic [7:0]             text_byte,
   output hce_pkg::dp_status_type status,
   output logic [7:0]             cipher_byte,
   output logic                   no_match,
   output logic                   group_last
);

   logic [4:0] table_ff [hce_pkg::ALPHA_SIZE];
   logic [4:0] group_ff [hce_pkg::GROUP_SIZE];
   logic [4:0] group_in [hce_pkg::GROUP_SIZE];
   logic [4:0] sum_ff   [hce_pkg::GROUP_SIZE];
   logic [1:0] fill_ff, fill_in;

   logic [7:0] lower_byte;
   logic [4:0] letter_idx;
   logic       is_letter;
   logic [4:0] letter_val;

   logic [7:0] g0, g1, g2;
   logic [4:0] row_sum;
   logic [4:0] hit_idx;
   logic       hit;

   logic [7:0] byte_ff;
   logic       miss_ff;
   logic       last_ff;

   // Lower-case conversion and table lookup of the incoming byte.
   always_comb begin
      if (text_byte >= hce_pkg::CHAR_UPPER_A && text_byte <= hce_pkg::CHAR_UPPER_Z) begin
         lower_byte = text_byte + hce_pkg::CASE_OFFSET;
      end else begin
         lower_byte = text_byte;
      end
      is_letter  = (lower_byte >= hce_pkg::CHAR_LOWER_A) &&
                   (lower_byte <= hce_pkg::CHAR_LOWER_Z);
      letter_idx = 5'(lower_byte - hce_pkg::CHAR_LOWER_A);
      letter_val = is_letter ? table_ff[letter_idx] : 5'd0;
   end

   assign status.blank = (text_byte == hce_pkg::CHAR_SPACE) ||
                         (text_byte >= hce_pkg::CHAR_TAB && text_byte <= hce_pkg::CHAR_CR);
   assign status.fill  = fill_ff;

   // Letter value table: written by load commands, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hce_pkg::ALPHA_SIZE; i++) begin
            table_ff[i] <= 5'd0;
         end
      end else if (cmd.write_entry && entry_index < 5'(hce_pkg::ALPHA_SIZE)) begin
         table_ff[entry_index] <= entry_value;
      end
   end

   // Pending group and fill count.
   always_comb begin
      fill_in = fill_ff;
      for (int i = 0; i < hce_pkg::GROUP_SIZE; i++) begin
         group_in[i] = group_ff[i];
      end
      if (cmd.store_letter) begin
         group_in[fill_ff] = letter_val;
         fill_in           = fill_ff + 2'd1;
      end else if (cmd.pad_group) begin
         for (int i = 0; i < hce_pkg::GROUP_SIZE; i++) begin
            if (2'(i) >= fill_ff) begin
               group_in[i] = table_ff[hce_pkg::PAD_INDEX];
            end
         end
      end else if (cmd.calc_sums) begin
         fill_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < hce_pkg::GROUP_SIZE; i++) begin
         group_ff[i] <= group_in[i];
      end
   end

   // Key rows {1,2,2}, {0,1,4}, {5,0,1} as shifts and adds.
   assign g0 = 8'(group_ff[0]);
   assign g1 = 8'(group_ff[1]);
   assign g2 = 8'(group_ff[2]);

   always_ff @(posedge clock) begin
      if (cmd.calc_sums) begin
         sum_ff[0] <= hce_pkg::mod26(g0 + (g1 << 1) + (g2 << 1));
         sum_ff[1] <= hce_pkg::mod26(g1 + (g2 << 2));
         sum_ff[2] <= hce_pkg::mod26((g0 << 2) + g0 + g2);
      end
   end

   // Reverse lookup: lowest table index whose value equals the row sum.
   assign row_sum = (cmd.row == 2'd0) ? sum_ff[0] :
                    (cmd.row == 2'd1) ? sum_ff[1] : sum_ff[2];

   always_comb begin
      hit     = 1'b0;
      hit_idx = 5'd0;
      for (int i = hce_pkg::ALPHA_SIZE - 1; i >= 0; i--) begin
         if (table_ff[i] == row_sum) begin
            hit     = 1'b1;
            hit_idx = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         byte_ff <= hit ? (hce_pkg::CHAR_LOWER_A + 8'(hit_idx)) : hce_pkg::NO_MATCH_CHAR;
         miss_ff <= !hit;
         last_ff <= (cmd.row == hce_pkg::LAST_ROW);
      end
   end

   assign cipher_byte = byte_ff;
   assign no_match    = miss_ff;
   assign group_last  = last_ff;

endmodule

// ===== hdl/hill_cipher_3x3_encrypt.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_3x3_encrypt: 3x3 Hill cipher encryptor over a byte stream.
// Load, blank, non-closing text and empty flush items keep the block idle and ready.
// A group-closing item passes through accept, sum and three result rows; the
// result rows follow one per cycle while the consumer keeps up.
// Synchronous active-high reset clears the letter table and empties the pending group.
// ----------------------------------------------------------------------------
//
// The block works on one item at a time. A controller (hce_ctrl) holds the
// request channel ready only while it is idle. A load item writes one entry of
// the 26-entry letter table. A text item is lower-cased, skipped if it is
// whitespace, and otherwise its table value joins the pending group. When the
// third value arrives, or a flush item pads a partial group with the value of
// 'x', the controller enters a sum state in which the datapath (hce_dp) forms the
// three key-row sums modulo 26 into registers. It then loads the three result
// rows, one per cycle, into the output register. Each row searches the table
// for the lowest matching index; a miss yields '?' with the no-match flag set.
// The output register lets the last row wait for the consumer while the block
// already accepts the next item. Downstream stalls hold the row sequence.
//
module hill_cipher_3x3_encrypt (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // entry_index[4:0], entry_value[9:5], text_byte[17:10]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // cipher_byte[7:0]
   output logic        rsp_tuser,   // no_match[0]
   output logic        rsp_tlast
);

   hce_pkg::ctrl_cmd_type  cmd;
   hce_pkg::dp_status_type status;

   logic [4:0] entry_index;
   logic [4:0] entry_value;
   logic [7:0] text_byte;

   // Unpack the request item fields.
   assign entry_index = req_tdata[4:0];
   assign entry_value = req_tdata[9:5];
   assign text_byte   = req_tdata[17:10];

   hce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .status     (status),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   hce_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .entry_index (entry_index),
      .entry_value (entry_value),
      .text_byte   (text_byte),
      .status      (status),
      .cipher_byte (rsp_tdata),
      .no_match    (rsp_tuser),
      .group_last  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // A text item that completes a group must stop further input at once.
   a_group_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == hce_pkg::CMD_TEXT && !status.blank &&
       status.fill == 2'd2) |=> !req_tready)
      else $error("input still ready after a group closed");

   // A result flagged as a miss carries the '?' character.
   a_miss_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == hce_pkg::NO_MATCH_CHAR))
      else $error("no-match result without the question mark");

   // A matched result is a lower-case letter.
   a_hit_letter: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         (rsp_tdata >= hce_pkg::CHAR_LOWER_A && rsp_tdata <= hce_pkg::CHAR_LOWER_Z))
      else $error("matched result outside a..z");

   // While waiting for input, the pending group never holds a full group.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (status.fill != 2'd3))
      else $error("pending group overfilled");
`endif

endmodule

// ===== tb/hill_cipher_3x3_encrypt_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_encrypt_test
// Self-checking bench for the 3x3 Hill cipher encryptor. A clocked driver
// feeds request items from a queue, a clocked monitor checks each result item
// in order against a behavioral predictor of the table, group and key.
// ----------------------------------------------------------------------------
module hill_cipher_3x3_encrypt_test;

   // Long receiver hold-off, in clock cycles, used once to back the block up.
   localparam int HOLD_CYCLES = 300;
   // Number of counted random request items in each of the three phases.
   localparam int PHASE_ITEMS = 135;
   // Drain time after the last expected result, in cycles.
   localparam int TAIL_CYCLES = 12;
   // Hard stop for the whole run, in ns: far beyond the slowest correct run.
   localparam int TIMEOUT_NS = 2_400_000;

   // One request item, as the predictor sees it.
   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] index;
      logic [4:0] entry_value;
      logic [7:0] text;
   } req_item_type;

   // One ciphertext letter as it should leave the block.
   typedef struct packed {
      logic [7:0] letter;
      logic       miss;
      logic       last;
   } cipher_letter_type;

   // Clock, reset and the block's ports. Every input has a known value at time
   // zero; reset starts high, is dropped once and is never raised again.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // entry_index[4:0], entry_value[9:5], text_byte[17:10]
   logic [1:0]  req_tuser = hce_pkg::CMD_NONE;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // cipher_byte[7:0]
   logic        rsp_tuser;   // no_match[0]
   logic        rsp_tlast;

   hill_cipher_3x3_encrypt dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stimulus and expectation stores.
   req_item_type      req_queue[$];
   cipher_letter_type cipher_queue[$];
   req_item_type      offered;

   // Predictor state: the letter table, the letters of the open group and how
   // many of them are held so far.
   logic [4:0] letter_table[hce_pkg::ALPHA_SIZE];
   logic [4:0] open_group[hce_pkg::GROUP_SIZE];
   int         group_fill = 0;

   // Idle rates in percent, set per phase, and the long hold-off handshake.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;

   // Run statistics.
   int errors = 0;
   int items_accepted = 0;
   int letters_checked = 0;
   int misses_seen = 0;
   int groups_closed = 0;
   int flushes_padded = 0;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Tab, line feed, vertical tab, form feed, carriage return and space are
   // dropped from the text without touching the group.
   function automatic logic is_blank(input logic [7:0] b);
      return (b == hce_pkg::CHAR_SPACE) ||
             (b >= hce_pkg::CHAR_TAB && b <= hce_pkg::CHAR_CR);
   endfunction

   // Only ASCII upper case is folded; anything outside a..z after folding,
   // high-bit bytes included, counts as value zero but still fills a slot.
   function automatic logic [4:0] letter_value(input logic [7:0] b);
      logic [7:0] folded;
      folded = b;
      if (b >= hce_pkg::CHAR_UPPER_A && b <= hce_pkg::CHAR_UPPER_Z) begin
         folded = b + hce_pkg::CASE_OFFSET;
      end
      if (folded >= hce_pkg::CHAR_LOWER_A && folded <= hce_pkg::CHAR_LOWER_Z) begin
         return letter_table[folded - hce_pkg::CHAR_LOWER_A];
      end
      return 5'd0;
   endfunction

   // Multiply the open group by the key {{1,2,2},{0,1,4},{5,0,1}} modulo 26
   // and turn each sum back into the lowest table index holding that value.
   task automatic encrypt_open_group();
      int                sums[hce_pkg::GROUP_SIZE];
      cipher_letter_type res;
      sums[0] = (open_group[0] + 2 * open_group[1] + 2 * open_group[2])
                % hce_pkg::ALPHA_SIZE;
      sums[1] = (open_group[1] + 4 * open_group[2]) % hce_pkg::ALPHA_SIZE;
      sums[2] = (5 * open_group[0] + open_group[2]) % hce_pkg::ALPHA_SIZE;
      for (int r = 0; r < hce_pkg::GROUP_SIZE; r++) begin
         res.letter = hce_pkg::NO_MATCH_CHAR;
         res.miss = 1'b1;
         // Walk downward so the lowest matching index is the one kept.
         for (int i = hce_pkg::ALPHA_SIZE - 1; i >= 0; i--) begin
            if (int'(letter_table[i]) == sums[r]) begin
               res.letter = hce_pkg::CHAR_LOWER_A + 8'(i);
               res.miss = 1'b0;
            end
         end
         res.last = (r == hce_pkg::GROUP_SIZE - 1);
         cipher_queue.push_back(res);
      end
      group_fill = 0;
      groups_closed++;
   endtask

   // Update the predicted state for one accepted request item.
   task automatic encrypt_request(input req_item_type it);
      case (it.cmd)
         hce_pkg::CMD_LOAD: begin
            // Indexes past 'z' are dropped; values 26..31 are kept as given.
            if (it.index < hce_pkg::ALPHA_SIZE) begin
               letter_table[it.index] = it.entry_value;
            end
         end
         hce_pkg::CMD_TEXT: begin
            if (!is_blank(it.text)) begin
               open_group[group_fill] = letter_value(it.text);
               group_fill++;
               if (group_fill == hce_pkg::GROUP_SIZE) begin
                  encrypt_open_group();
               end
            end
         end
         hce_pkg::CMD_FLUSH: begin
            // A partial group is padded with 'x' as the table reads now;
            // an empty group gives nothing.
            if (group_fill != 0) begin
               while (group_fill < hce_pkg::GROUP_SIZE) begin
                  open_group[group_fill] = letter_table[hce_pkg::PAD_INDEX];
                  group_fill++;
               end
               flushes_padded++;
               encrypt_open_group();
            end
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers the next queued item whenever the slot is free, with
   // random gaps. The item in flight is fed to the predictor at the edge that
   // accepts it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= hce_pkg::CMD_NONE;
      end else begin
         if (req_tvalid && req_tready) begin
            encrypt_request(offered);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = req_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, offered.text, offered.entry_value, offered.index};
               req_tuser <= offered.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver ready: random stalls, plus one long hold-off on request. The
   // hold-off is counted here so the driver keeps offering items meanwhile.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every accepted result item is checked against the oldest
   // expected letter, field by field.
   // ------------------------------------------------------------------------
   cipher_letter_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: got letter %h no_match %b last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = cipher_queue.pop_front();
            letters_checked++;
            if (rsp_tuser) begin
               misses_seen++;
            end
            if (rsp_tdata !== want.letter) begin
               errors++;
               $display("%0t: cipher_byte mismatch: expected %h, got %h",
                        $time, want.letter, rsp_tdata);
            end
            if (rsp_tuser !== want.miss) begin
               errors++;
               $display("%0t: no_match mismatch: expected %b, got %b",
                        $time, want.miss, rsp_tuser);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: group_last mismatch: expected %b, got %b",
                        $time, want.last, rsp_tlast);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus builders. Fields that a command does not use carry random bits,
   // since the block must ignore them.
   // ------------------------------------------------------------------------
   function automatic req_item_type random_fields();
      req_item_type it;
      it.cmd = 2'($urandom_range(3));
      it.index = 5'($urandom_range(31));
      it.entry_value = 5'($urandom_range(31));
      it.text = 8'($urandom_range(255));
      return it;
   endfunction

   task automatic queue_load(input int idx, input int val);
      req_item_type it;
      it = random_fields();
      it.cmd = hce_pkg::CMD_LOAD;
      it.index = 5'(idx);
      it.entry_value = 5'(val);
      req_queue.push_back(it);
   endtask

   task automatic queue_text(input logic [7:0] b);
      req_item_type it;
      it = random_fields();
      it.cmd = hce_pkg::CMD_TEXT;
      it.text = b;
      req_queue.push_back(it);
   endtask

   task automatic queue_command(input logic [1:0] c);
      req_item_type it;
      it = random_fields();
      it.cmd = c;
      req_queue.push_back(it);
   endtask

   // Rewrite all 26 entries: mostly a permutation, so every sum finds a
   // letter, sometimes raw values that leave holes and duplicates.
   task automatic queue_table_reload();
      int perm[hce_pkg::ALPHA_SIZE];
      int j, t;
      logic scrambled;
      scrambled = ($urandom_range(3) == 0);
      for (int i = 0; i < hce_pkg::ALPHA_SIZE; i++) begin
         perm[i] = i;
      end
      for (int i = hce_pkg::ALPHA_SIZE - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      for (int i = 0; i < hce_pkg::ALPHA_SIZE; i++) begin
         queue_load(i, scrambled ? $urandom_range(31) : perm[i]);
      end
   endtask

   // Mostly well-formed text in random case with a little noise, the odd
   // table write, flushes at any group position and ignored commands.
   task automatic queue_random_items(input int count);
      int counted;
      int pick;
      logic [7:0] b;
      counted = 0;
      while (counted < count) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            queue_table_reload();
            counted += hce_pkg::ALPHA_SIZE;
         end else if (pick < 10) begin
            queue_load(($urandom_range(7) == 0)
                          ? $urandom_range(31, hce_pkg::ALPHA_SIZE)
                          : $urandom_range(hce_pkg::ALPHA_SIZE - 1),
                       $urandom_range(31));
            counted++;
         end else if (pick < 80) begin
            b = hce_pkg::CHAR_LOWER_A + 8'($urandom_range(hce_pkg::ALPHA_SIZE - 1));
            if ($urandom_range(2) == 0) begin
               b = b - hce_pkg::CASE_OFFSET;
            end
            queue_text(b);
            counted++;
         end else if (pick < 86) begin
            // Blanks are skipped by the block and not counted.
            b = ($urandom_range(5) == 5) ? hce_pkg::CHAR_SPACE
                                         : hce_pkg::CHAR_TAB + 8'($urandom_range(4));
            queue_text(b);
         end else if (pick < 92) begin
            queue_text(8'($urandom_range(255)));
            counted++;
         end else if (pick < 97) begin
            queue_command(hce_pkg::CMD_FLUSH);
            counted++;
         end else begin
            queue_command(hce_pkg::CMD_NONE);
         end
      end
   endtask

   // Wait, sampling away from the active edge, until every queued item has
   // been accepted and every expected letter has been seen.
   task automatic wait_drained();
      @(negedge clock);
      while (req_queue.size() != 0 || req_tvalid || cipher_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < hce_pkg::ALPHA_SIZE; i++) begin
         letter_table[i] = 5'd0;
      end
      for (int i = 0; i < hce_pkg::GROUP_SIZE; i++) begin
         open_group[i] = 5'd0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase one: the sender rarely idles, the receiver stalls about half
      // the time.
      @(negedge clock);
      send_idle_pct = 8;
      recv_idle_pct = 52;

      // Directed part. With the table still cleared every letter is value
      // zero, so the first group encrypts to three copies of 'a'.
      queue_text("a");
      queue_text("b");
      queue_text("c");
      // Extremes of the table write: first and last entry, a value that can
      // never match a sum, an index past 'z' that must be ignored, and the
      // entry used for padding.
      queue_load(0, hce_pkg::ALPHA_SIZE - 1);
      queue_load(hce_pkg::ALPHA_SIZE - 1, 0);
      queue_load(3, 31);
      queue_load(31, 5);
      queue_load(hce_pkg::PAD_INDEX, 7);
      // Upper case is folded; the blanks in between are skipped; a zero byte
      // and an all-ones byte take value zero and complete the group.
      queue_text("Z");
      queue_text(hce_pkg::CHAR_SPACE);
      queue_text(hce_pkg::CHAR_TAB);
      queue_text(hce_pkg::CHAR_CR);
      queue_text(8'h00);
      queue_text(8'hFF);
      // A high-bit byte is not folded; two letters then a flush pads one 'x'.
      queue_text(8'h80);
      queue_text("x");
      queue_command(hce_pkg::CMD_FLUSH);
      // A flush with nothing pending and an ignored command emit nothing.
      queue_command(hce_pkg::CMD_FLUSH);
      queue_command(hce_pkg::CMD_NONE);
      // One letter whose value never matches, then a flush pads two 'x'.
      queue_text("D");
      queue_command(hce_pkg::CMD_FLUSH);

      // The sender pauses here until the directed results have all come.
      wait_drained();

      // Random part, starting from a full table. While the receiver is held
      // off for a long stretch the block fills up and stalls its input.
      queue_table_reload();
      queue_random_items(PHASE_ITEMS);
      holds_asked = holds_asked + 1;
      wait_drained();

      // Phase two: the sender idles often, the receiver rarely.
      send_idle_pct = 52;
      recv_idle_pct = 8;
      queue_random_items(PHASE_ITEMS);
      wait_drained();

      // Phase three: full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_items(PHASE_ITEMS);
      wait_drained();

      // Let any stray result surface before the verdict.
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d items: table writes, text, flushes and ignored commands,",
               items_accepted);
      $display("closing %0d groups (%0d padded) into %0d letters, %0d with no match.",
               groups_closed, flushes_padded, letters_checked, misses_seen);
      if (errors == 0) begin
         $display("** hill_cipher_3x3_encrypt: PASSED **");
      end else begin
         $display("** hill_cipher_3x3_encrypt: FAILED **");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d items queued and %0d letters outstanding.",
               req_queue.size(), cipher_queue.size());
      $display("** hill_cipher_3x3_encrypt: FAILED **");
      $finish;
   end

endmodule
